// ===== sv/jtpg_pkg.sv =====
package jtpg_pkg;

	// Field widths of the item ports
	localparam int TAG_W   = 3;
	localparam int ANG_W   = 16;
	localparam int MODE_W  = 2;
	localparam int IDX_W   = 6;
	localparam int CNT_W   = 7;

	// Register reset value and the lower bound on the point count
	localparam logic [CNT_W-1:0] PTS_RESET = 7'd16;
	localparam logic [CNT_W-1:0] PTS_MIN   = 7'd4;

	// Saturation bounds of a position
	localparam logic signed [ANG_W-1:0] POS_MAX = 16'sh7FFF;
	localparam logic signed [ANG_W-1:0] POS_MIN = 16'sh8000;

	// Velocity profiles
	typedef enum logic [MODE_W-1:0] {
		MODE_RAMPS     = 2'd0,
		MODE_CONST     = 2'd1,
		MODE_RAMP_UP   = 2'd2,
		MODE_RAMP_DOWN = 2'd3
	} mode_t;

	// Datapath operation of one microcode step
	typedef enum logic [3:0] {
		OP_NOP,
		OP_FETCH,
		OP_SETUP,
		OP_SEGSEL,
		OP_MULP,
		OP_MULD,
		OP_DIVINIT,
		OP_DIVSTEP,
		OP_ROUND,
		OP_EMIT,
		OP_NEXT
	} op_t;

	// Jump condition of one microcode step
	typedef enum logic [2:0] {
		COND_NONE,
		COND_ALWAYS,
		COND_NO_IN,
		COND_DIV_BUSY,
		COND_OUT_FULL,
		COND_MORE
	} cond_t;

	typedef logic [3:0] step_t;

	localparam step_t ST_FETCH   = 4'd0;
	localparam step_t ST_SETUP   = 4'd1;
	localparam step_t ST_SEGSEL  = 4'd2;
	localparam step_t ST_MULP    = 4'd3;
	localparam step_t ST_MULD    = 4'd4;
	localparam step_t ST_DIVINIT = 4'd5;
	localparam step_t ST_DIVSTEP = 4'd6;
	localparam step_t ST_ROUND   = 4'd7;
	localparam step_t ST_EMIT    = 4'd8;
	localparam step_t ST_NEXT    = 4'd9;
	localparam step_t ST_DONE    = 4'd10;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		step_t target;
	} uword_t;

	// Control store: taken jump goes to target, otherwise to the next step
	function automatic uword_t ucode_rom(input step_t s);
		uword_t w;
		begin
			unique case (s)
				ST_FETCH:   w = '{OP_FETCH,   COND_NO_IN,    ST_FETCH};
				ST_SETUP:   w = '{OP_SETUP,   COND_NONE,     ST_FETCH};
				ST_SEGSEL:  w = '{OP_SEGSEL,  COND_NONE,     ST_FETCH};
				ST_MULP:    w = '{OP_MULP,    COND_NONE,     ST_FETCH};
				ST_MULD:    w = '{OP_MULD,    COND_NONE,     ST_FETCH};
				ST_DIVINIT: w = '{OP_DIVINIT, COND_NONE,     ST_FETCH};
				ST_DIVSTEP: w = '{OP_DIVSTEP, COND_DIV_BUSY, ST_DIVSTEP};
				ST_ROUND:   w = '{OP_ROUND,   COND_NONE,     ST_FETCH};
				ST_EMIT:    w = '{OP_EMIT,    COND_OUT_FULL, ST_EMIT};
				ST_NEXT:    w = '{OP_NEXT,    COND_MORE,     ST_SEGSEL};
				ST_DONE:    w = '{OP_NOP,     COND_ALWAYS,   ST_FETCH};
				default:    w = '{OP_NOP,     COND_ALWAYS,   ST_FETCH};
			endcase
			return w;
		end
	endfunction

endpackage

// ===== sv/joint_trajectory_profile_generator_top.sv =====
// Channel   Direction  Signals                                              Accepted when
// in        input      in_valid/in_ready, joint_tag, start_angle,          in_valid & in_ready
//                      end_angle, profile_mode
// out       output     out_valid/out_ready, joint_tag_out, point_index,    out_valid & out_ready
//                      position, last_point
// cfg       input      cfg_valid/cfg_ready, point_count                    cfg_valid & cfg_ready
//
// Each point passes through seven control steps plus a restoring divider that retires one
// quotient bit per cycle over the 33-bit scaled product at MAX_POINTS = 64. A stalled
// output holds the sequencer on its emit step; the next item is taken only after the
// last point of the current one has been loaded into the output register.
// Reset clears the sequencer, the output valid and sets point_count to 16.
module joint_trajectory_profile_generator_top #(
	parameter int MAX_POINTS = 64
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [jtpg_pkg::TAG_W-1:0]         joint_tag,
	input  logic signed [jtpg_pkg::ANG_W-1:0]  start_angle,
	input  logic signed [jtpg_pkg::ANG_W-1:0]  end_angle,
	input  logic [jtpg_pkg::MODE_W-1:0]        profile_mode,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [jtpg_pkg::TAG_W-1:0]         joint_tag_out,
	output logic [jtpg_pkg::IDX_W-1:0]         point_index,
	output logic signed [jtpg_pkg::ANG_W-1:0]  position,
	output logic                               last_point,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [jtpg_pkg::CNT_W-1:0]         point_count
);
	import jtpg_pkg::*;

	// Derived widths
	localparam int NW   = $clog2(MAX_POINTS + 1);           // point counter
	localparam int NNW  = 2 * NW;                           // N*N
	localparam int YW   = NW + 6;                           // multiplier operand, signed
	localparam int CW   = 2 * NW + 5;                       // additive term, signed
	localparam int AW   = 2 * NW + 8;                       // numerator before truncation
	localparam int PMAX = 6 * MAX_POINTS * MAX_POINTS + 4 * MAX_POINTS;
	localparam int PW   = $clog2(PMAX + 1) + 1;             // numerator, signed
	localparam int DLW  = ANG_W + 1;                        // angle difference, signed
	localparam int PRW  = DLW + PW;                         // scaled product, signed
	localparam int DW   = PRW;                              // dividend
	localparam int DVW  = 2 * NW + 4;                       // divisor 12*N*N
	localparam int DCW  = $clog2(DW);                       // divider bit counter
	localparam int SW   = DW + 2;                           // final sum, signed

	// Sequencer
	step_t  pc_q, pc_d;
	uword_t uw;
	logic   cond_hit;
	logic   out_load;

	// Configuration and per-item registers
	logic [CNT_W-1:0]       pts_q;
	logic [TAG_W-1:0]       tag_q;
	logic signed [ANG_W-1:0] r0_q;
	logic signed [DLW-1:0]  d_q;
	mode_t                  mode_q;
	logic [NW-1:0]          n_q, k_q, q_q, h_q, t_q;
	logic [NNW-1:0]         nn_q;

	// Datapath registers
	logic [NW-1:0]          x_q;
	logic signed [YW-1:0]   y_q;
	logic signed [CW-1:0]   c_q;
	logic signed [PW-1:0]   p_q;
	logic signed [PRW-1:0]  prod_q;
	logic                   neg_q;
	logic [DW-1:0]          quo_q;
	logic [DVW-1:0]         rem_q, div_q;
	logic [DCW-1:0]         dcnt_q;
	logic signed [ANG_W-1:0] pos_q;

	// Output register
	logic                   out_valid_q;
	logic [TAG_W-1:0]       out_tag_q;
	logic [IDX_W-1:0]       out_idx_q;
	logic signed [ANG_W-1:0] out_pos_q;
	logic                   out_last_q;

	// Combinational datapath values
	logic [NW-1:0]          n_clamp;
	logic [NW+1:0]          n3_w;
	logic [NW-1:0]          i_w, m_w;
	logic signed [YW-1:0]   k_s, n_s, h_s, m_s;
	logic signed [CW-1:0]   nn_s;
	logic [NW-1:0]          x_w;
	logic signed [YW-1:0]   y_w;
	logic signed [CW-1:0]   c_w;
	logic signed [AW-1:0]   pxy_w, pfull_w;
	logic signed [PRW-1:0]  mag_w;
	logic [DVW-1:0]         den_w, den2_w;
	logic [DVW:0]           shl_w, sub_w;
	logic                   ge_w;
	logic signed [DW:0]     qs_w, qsgn_w;
	logic signed [SW-1:0]   sum_w;
	logic signed [ANG_W-1:0] sat_w;

	// Control word of the current step
	assign uw = ucode_rom(pc_q);

	// Jump condition
	always_comb begin
		unique case (uw.cond)
			COND_NONE:     cond_hit = 1'b0;
			COND_ALWAYS:   cond_hit = 1'b1;
			COND_NO_IN:    cond_hit = !in_valid;
			COND_DIV_BUSY: cond_hit = (dcnt_q != '0);
			COND_OUT_FULL: cond_hit = out_valid_q && !out_ready;
			COND_MORE:     cond_hit = (k_q != n_q);
			default:       cond_hit = 1'b1;
		endcase
	end

	// Next step
	always_comb begin
		if (cond_hit) begin
			pc_d = uw.target;
		end else begin
			pc_d = pc_q + 4'd1;
		end
	end

	// Handshake outputs
	always_comb begin
		in_ready  = (uw.op == OP_FETCH);
		cfg_ready = 1'b1;
		out_load  = (uw.op == OP_EMIT) && (!out_valid_q || out_ready);
	end

	// Point count clamp and segment bounds
	always_comb begin
		priority if (pts_q < PTS_MIN) begin
			n_clamp = NW'(PTS_MIN);
		end else if (pts_q > CNT_W'(MAX_POINTS)) begin
			n_clamp = NW'(MAX_POINTS);
		end else begin
			n_clamp = NW'(pts_q);
		end
		n3_w = (NW+2)'({n_q, 1'b0}) + (NW+2)'(n_q);
	end

	// Segment selection: numerator = x * y + c
	always_comb begin
		i_w  = k_q - 1'b1;
		m_w  = k_q - h_q;
		k_s  = signed'(YW'(k_q));
		n_s  = signed'(YW'(n_q));
		h_s  = signed'(YW'(h_q));
		m_s  = signed'(YW'(m_w));
		nn_s = signed'(CW'(nn_q));
		x_w  = k_q;
		y_w  = '0;
		c_w  = '0;
		unique case (mode_q)
			MODE_RAMPS: begin
				priority if (i_w < q_q) begin
					x_w = k_q;
					y_w = k_s <<< 4;
				end else if (i_w < t_q) begin
					x_w = n_q;
					y_w = (k_s <<< 3) - n_s;
				end else begin
					x_w = k_q;
					y_w = (n_s <<< 5) - (k_s <<< 4);
					c_w = -((nn_s <<< 3) + (nn_s <<< 1));
				end
			end
			MODE_CONST: begin
				x_w = k_q;
				y_w = (n_s <<< 2) + (n_s <<< 1);
			end
			MODE_RAMP_UP: begin
				priority if (i_w < h_q) begin
					x_w = k_q;
					y_w = k_s <<< 3;
				end else begin
					x_w = n_q;
					y_w = (k_s - h_s) <<< 3;
					c_w = nn_s <<< 1;
				end
			end
			MODE_RAMP_DOWN: begin
				priority if (i_w < h_q) begin
					x_w = k_q;
					y_w = n_s <<< 3;
				end else begin
					x_w = m_w;
					y_w = (n_s - m_s) <<< 3;
					c_w = nn_s <<< 2;
				end
			end
			default: begin
				x_w = k_q;
				y_w = '0;
			end
		endcase
	end

	// Numerator, magnitude, divider step, rounding and saturation
	always_comb begin
		pxy_w   = signed'({1'b0, x_q}) * y_q;
		pfull_w = pxy_w + AW'(c_q);
		mag_w   = prod_q[PRW-1] ? -prod_q : prod_q;
		den_w   = DVW'({nn_q, 2'b00}) + DVW'({nn_q, 1'b0});
		den2_w  = DVW'({nn_q, 3'b000}) + DVW'({nn_q, 2'b00});
		shl_w   = {rem_q, quo_q[DW-1]};
		sub_w   = shl_w - {1'b0, div_q};
		ge_w    = (shl_w >= {1'b0, div_q});
		qs_w    = signed'({1'b0, quo_q});
		qsgn_w  = neg_q ? -qs_w : qs_w;
		sum_w   = SW'(r0_q) + SW'(qsgn_w);
		priority if (sum_w > SW'(POS_MAX)) begin
			sat_w = POS_MAX;
		end else if (sum_w < SW'(POS_MIN)) begin
			sat_w = POS_MIN;
		end else begin
			sat_w = sum_w[ANG_W-1:0];
		end
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q        <= ST_FETCH;
			pts_q       <= PTS_RESET;
			out_valid_q <= 1'b0;
			n_q         <= NW'(PTS_RESET);
			k_q         <= '0;
			dcnt_q      <= '0;
		end else begin
			pc_q <= pc_d;
			if (cfg_valid && cfg_ready) begin
				pts_q <= point_count;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (uw.op)
				OP_FETCH: begin
					if (in_valid) begin
						n_q <= n_clamp;
						k_q <= NW'(1);
					end
				end
				OP_DIVINIT: dcnt_q <= DCW'(DW - 1);
				OP_DIVSTEP: dcnt_q <= dcnt_q - 1'b1;
				OP_NEXT: begin
					if (k_q != n_q) begin
						k_q <= k_q + 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		unique case (uw.op)
			OP_FETCH: begin
				tag_q  <= joint_tag;
				r0_q   <= start_angle;
				d_q    <= DLW'(end_angle) - DLW'(start_angle);
				mode_q <= mode_t'(profile_mode);
			end
			OP_SETUP: begin
				nn_q <= n_q * n_q;
				q_q  <= NW'(n_q >> 2);
				h_q  <= NW'(n_q >> 1);
				t_q  <= n3_w[NW+1:2];
			end
			OP_SEGSEL: begin
				x_q <= x_w;
				y_q <= y_w;
				c_q <= c_w;
			end
			OP_MULP: p_q <= pfull_w[PW-1:0];
			OP_MULD: prod_q <= d_q * p_q;
			OP_DIVINIT: begin
				neg_q <= prod_q[PRW-1];
				quo_q <= DW'({mag_w[PRW-2:0], 1'b0}) + DW'(den_w);
				div_q <= den2_w;
				rem_q <= '0;
			end
			OP_DIVSTEP: begin
				rem_q <= ge_w ? sub_w[DVW-1:0] : shl_w[DVW-1:0];
				quo_q <= {quo_q[DW-2:0], ge_w};
			end
			OP_ROUND: pos_q <= sat_w;
			default: begin
			end
		endcase
		if (out_load) begin
			out_tag_q  <= tag_q;
			out_idx_q  <= IDX_W'(k_q - 1'b1);
			out_pos_q  <= pos_q;
			out_last_q <= (k_q == n_q);
		end
	end

	assign out_valid     = out_valid_q;
	assign joint_tag_out = out_tag_q;
	assign point_index   = out_idx_q;
	assign position      = out_pos_q;
	assign last_point    = out_last_q;

`ifndef SYNTHESIS
	// The point counter stays within the run while a move is in progress
	a_k_range: assert property (@(posedge clk) disable iff (!arst_n)
		(pc_q != ST_FETCH) |-> (k_q != '0 && k_q <= n_q))
		else $error("point counter out of range");

	// Partial remainder stays below the divisor on every divider step
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(uw.op == OP_DIVSTEP) |-> (rem_q < div_q))
		else $error("divider remainder not below divisor");

	// The last flag of a loaded item matches its index
	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> (last_point == (point_index == IDX_W'(n_q - 1'b1))))
		else $error("last_point does not match point_index");
`endif

endmodule
